// File: rtl/bmm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the bipartite matching core.
// No dependencies; imported by bmm_ram users and the top level.
package bmm_pkg;

   localparam int MAX_U = 64;
   localparam int MAX_V = 64;

   localparam int ROW_W   = MAX_V;               // adjacency row width
   localparam int RIDX_W  = $clog2(MAX_U);       // row index
   localparam int COL_W   = $clog2(MAX_V);       // right column index
   localparam int VERT_W  = $clog2(MAX_U + 1);   // 1-based left vertex, 0 = nil
   localparam int CNT_W   = 7;                   // register and count width
   localparam int LAYER_W = 8;
   localparam int QA_W    = $clog2(MAX_U + 1);   // queue address
   localparam int SA_W    = $clog2(MAX_U);       // stack address (frames below top)
   localparam int DEPTH_W = $clog2(MAX_U + 2);   // frames on stack, 0..MAX_U+1
   localparam int NEXT_W  = $clog2(MAX_V + 1);   // next column to try, 0..MAX_V

   localparam logic [LAYER_W-1:0] LAYER_INF = '1;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_U_COUNT = 2'd0;
   localparam logic [1:0] CSR_V_COUNT = 2'd1;

   // One search stack frame: left vertex (0-based) and next column to try
   typedef struct packed {
      logic [RIDX_W-1:0] vidx;
      logic [NEXT_W-1:0] next;
   } frame_type;

   typedef struct packed {
      logic             hit;
      logic [COL_W-1:0] idx;
   } ffs_type;

   // Lowest set bit of a row
   function automatic ffs_type find_first(input logic [ROW_W-1:0] v);
      ffs_type r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.hit = 1'b1;
            r.idx = COL_W'(i);
         end
      end
      return r;
   endfunction

   // Ones in bit positions below n (n may equal ROW_W)
   function automatic logic [ROW_W-1:0] low_mask(input logic [NEXT_W-1:0] n);
      logic [ROW_W:0] w;
      w = ({{ROW_W{1'b0}}, 1'b1} << n) - 1'b1;
      return w[ROW_W-1:0];
   endfunction

endpackage

// File: rtl/bmm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/bipartite_max_matching_core.sv
`timescale 1ns / 1ps
// Maximum bipartite matching core: row loader and Hopcroft-Karp sequencer.
// Depends on bmm_pkg and bmm_ram.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+---------------------------
//  request | req_row_index, req_row_bits, req_last_row | start & !busy
//  result  | rsp_matching_size                        | rsp_valid, one cycle
//  config  | csr_index, csr_wdata                     | csr_valid & csr_ready
//
// A row word is written to the adjacency RAM; a last_row word also starts the
// matching, and busy stays high until the result strobe. Each phase is paced
// by the single read port of the layer and partner RAMs, and each round opens
// with a layer init pass. Synchronous reset idles the sequencer, sets the CSR
// counts to their maximum and clears queue, stack, count and match flags; RAM
// contents are not cleared (partner entries use valid flags).
module bipartite_max_matching_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bmm_pkg::RIDX_W-1:0]    req_row_index,
   input  logic [bmm_pkg::ROW_W-1:0]     req_row_bits,
   input  logic                          req_last_row,
   output logic                          rsp_valid,
   output logic [bmm_pkg::CNT_W-1:0]     rsp_matching_size,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [bmm_pkg::CNT_W-1:0]     csr_wdata
);
   import bmm_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_BFS_INIT = 5'd1;
   localparam logic [4:0] S_BFS_POP  = 5'd2;
   localparam logic [4:0] S_BFS_QW   = 5'd3;
   localparam logic [4:0] S_BFS_LD   = 5'd4;
   localparam logic [4:0] S_BFS_SCAN = 5'd5;
   localparam logic [4:0] S_BFS_RP   = 5'd6;
   localparam logic [4:0] S_BFS_LW   = 5'd7;
   localparam logic [4:0] S_LAY_CHK  = 5'd8;
   localparam logic [4:0] S_AUG_NEXT = 5'd9;
   localparam logic [4:0] S_DFS_LD   = 5'd10;
   localparam logic [4:0] S_DFS_SCAN = 5'd11;
   localparam logic [4:0] S_DFS_RP   = 5'd12;
   localparam logic [4:0] S_DFS_LW   = 5'd13;
   localparam logic [4:0] S_DFS_POP  = 5'd14;
   localparam logic [4:0] S_AUG_RD   = 5'd15;
   localparam logic [4:0] S_AUG_WR   = 5'd16;

   localparam logic [CNT_W-1:0]   CNT_MAX_U = CNT_W'(MAX_U);
   localparam logic [CNT_W-1:0]   CNT_MAX_V = CNT_W'(MAX_V);
   localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_U + 1);

   logic [4:0]         state_ff, state_in;
   logic [CNT_W-1:0]   u_count_ff, u_count_in, v_count_ff, v_count_in;
   logic [CNT_W-1:0]   nu_ff, nu_in, nv_ff, nv_in;
   logic [LAYER_W-1:0] lay_nil_ff, lay_nil_in, cur_layer_ff, cur_layer_in;
   logic [QA_W:0]      q_head_ff, q_head_in, q_tail_ff, q_tail_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VERT_W:0]    outer_u_ff, outer_u_in, init_ff, init_in;
   logic [VERT_W-1:0]  cur_vert_ff, cur_vert_in, w_ff, w_in;
   logic [NEXT_W-1:0]  cur_next_ff, cur_next_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [COL_W-1:0]   cand_col_ff, cand_col_in;
   logic [MAX_V-1:0]   rp_valid_ff, rp_valid_in;
   logic [MAX_U-1:0]   lmatch_ff, lmatch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_size_ff, rsp_size_in;

   // RAM ports
   logic               adj_we;
   logic [RIDX_W-1:0]  adj_waddr, adj_raddr;
   logic [ROW_W-1:0]   adj_wdata, adj_rdata;
   logic               lay_we;
   logic [RIDX_W-1:0]  lay_waddr, lay_raddr;
   logic [LAYER_W-1:0] lay_wdata, lay_rdata;
   logic               rp_we;
   logic [COL_W-1:0]   rp_waddr, rp_raddr;
   logic [VERT_W-1:0]  rp_wdata, rp_rdata;
   logic               q_we;
   logic [QA_W-1:0]    q_waddr, q_raddr;
   logic [VERT_W-1:0]  q_wdata, q_rdata;
   logic               st_we;
   logic [SA_W-1:0]    st_waddr, st_raddr;
   frame_type          st_wdata, st_rdata;

   logic [ROW_W-1:0]   nv_mask;
   ffs_type            first;
   logic [VERT_W-1:0]  w_now;
   logic [LAYER_W-1:0] layer_up;
   logic [RIDX_W-1:0]  init_idx, outer_idx, cur_idx, w_idx, st_vert_idx;

   bmm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_U)) u_adj (
      .clock(clock), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
      .raddr(adj_raddr), .rdata(adj_rdata));
   bmm_ram #(.WIDTH(LAYER_W), .DEPTH(MAX_U)) u_layer (
      .clock(clock), .we(lay_we), .waddr(lay_waddr), .wdata(lay_wdata),
      .raddr(lay_raddr), .rdata(lay_rdata));
   bmm_ram #(.WIDTH(VERT_W), .DEPTH(MAX_V)) u_rpart (
      .clock(clock), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
      .raddr(rp_raddr), .rdata(rp_rdata));
   bmm_ram #(.WIDTH(VERT_W), .DEPTH(MAX_U + 1)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));
   bmm_ram #(.WIDTH($bits(frame_type)), .DEPTH(MAX_U)) u_stack (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(st_raddr), .rdata(st_rdata));

   assign busy              = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matching_size = rsp_size_ff;

   // Shared helpers for the sequencer
   assign nv_mask     = low_mask(NEXT_W'(nv_ff));
   assign first       = find_first(row_ff);
   assign w_now       = rp_valid_ff[cand_col_ff] ? rp_rdata : '0;
   assign layer_up    = cur_layer_ff + LAYER_W'(1);
   assign init_idx    = RIDX_W'(init_ff - 1'b1);
   assign outer_idx   = RIDX_W'(outer_u_ff - 1'b1);
   assign cur_idx     = RIDX_W'(cur_vert_ff - 1'b1);
   assign w_idx       = RIDX_W'(w_now - 1'b1);
   assign st_vert_idx = st_rdata.vidx;

   // Sequencer: BFS layering, then DFS augmentation with an explicit stack
   always_comb begin
      state_in     = state_ff;
      u_count_in   = u_count_ff;
      v_count_in   = v_count_ff;
      nu_in        = nu_ff;
      nv_in        = nv_ff;
      lay_nil_in   = lay_nil_ff;
      cur_layer_in = cur_layer_ff;
      q_head_in    = q_head_ff;
      q_tail_in    = q_tail_ff;
      cnt_in       = cnt_ff;
      outer_u_in   = outer_u_ff;
      init_in      = init_ff;
      cur_vert_in  = cur_vert_ff;
      cur_next_in  = cur_next_ff;
      w_in         = w_ff;
      row_in       = row_ff;
      depth_in     = depth_ff;
      cand_col_in  = cand_col_ff;
      rp_valid_in  = rp_valid_ff;
      lmatch_in    = lmatch_ff;
      rsp_valid_in = 1'b0;
      rsp_size_in  = rsp_size_ff;

      adj_we = 1'b0; adj_waddr = req_row_index; adj_wdata = req_row_bits;
      adj_raddr = cur_idx;
      lay_we = 1'b0; lay_waddr = cur_idx; lay_wdata = LAYER_INF; lay_raddr = cur_idx;
      rp_we = 1'b0; rp_waddr = cand_col_ff; rp_wdata = cur_vert_ff;
      rp_raddr = first.idx;
      q_we = 1'b0; q_waddr = QA_W'(q_tail_ff); q_wdata = '0;
      q_raddr = QA_W'(q_head_ff);
      st_we = 1'b0; st_waddr = SA_W'(depth_ff - 1'b1);
      st_wdata = '{vidx: cur_idx, next: cur_next_ff};
      st_raddr = SA_W'(depth_ff - 2'd2);

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_U_COUNT: u_count_in = csr_wdata;
            CSR_V_COUNT: v_count_in = csr_wdata;
            default:     ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               adj_we = 1'b1;
               if (req_last_row) begin
                  rp_valid_in = '0;
                  lmatch_in   = '0;
                  cnt_in      = '0;
                  nu_in       = (u_count_ff > CNT_MAX_U) ? CNT_MAX_U : u_count_ff;
                  nv_in       = (v_count_ff > CNT_MAX_V) ? CNT_MAX_V : v_count_ff;
                  init_in     = (VERT_W + 1)'(1);
                  q_head_in   = '0;
                  q_tail_in   = '0;
                  state_in    = S_BFS_INIT;
               end
            end
         end
         // free left vertices get layer 0 and go into the queue
         S_BFS_INIT: begin
            if (init_ff > (VERT_W + 1)'(nu_ff)) begin
               lay_nil_in = LAYER_INF;
               state_in   = S_BFS_POP;
            end else begin
               lay_we    = 1'b1;
               lay_waddr = init_idx;
               lay_wdata = lmatch_ff[init_idx] ? LAYER_INF : '0;
               if (!lmatch_ff[init_idx]) begin
                  q_we      = 1'b1;
                  q_wdata   = VERT_W'(init_ff);
                  q_tail_in = q_tail_ff + 1'b1;
               end
               init_in = init_ff + 1'b1;
            end
         end
         S_BFS_POP: begin
            if (q_head_ff == q_tail_ff) begin
               state_in = S_LAY_CHK;
            end else begin
               q_head_in = q_head_ff + 1'b1;
               state_in  = S_BFS_QW;
            end
         end
         S_BFS_QW: begin
            if (q_rdata == '0) begin
               state_in = S_BFS_POP;
            end else begin
               cur_vert_in = q_rdata;
               adj_raddr   = RIDX_W'(q_rdata - 1'b1);
               lay_raddr   = RIDX_W'(q_rdata - 1'b1);
               state_in    = S_BFS_LD;
            end
         end
         S_BFS_LD: begin
            cur_layer_in = lay_rdata;
            row_in       = adj_rdata & nv_mask;
            state_in     = (lay_rdata >= lay_nil_ff) ? S_BFS_POP : S_BFS_SCAN;
         end
         S_BFS_SCAN: begin
            if (!first.hit) begin
               state_in = S_BFS_POP;
            end else begin
               cand_col_in          = first.idx;
               row_in[first.idx]    = 1'b0;
               state_in             = S_BFS_RP;
            end
         end
         S_BFS_RP: begin
            if (w_now == '0) begin
               if (lay_nil_ff == LAYER_INF) begin
                  lay_nil_in = layer_up;
                  q_we       = 1'b1;
                  q_wdata    = '0;
                  q_tail_in  = q_tail_ff + 1'b1;
               end
               state_in = S_BFS_SCAN;
            end else begin
               w_in      = w_now;
               lay_raddr = w_idx;
               state_in  = S_BFS_LW;
            end
         end
         S_BFS_LW: begin
            if (lay_rdata == LAYER_INF) begin
               lay_we    = 1'b1;
               lay_waddr = RIDX_W'(w_ff - 1'b1);
               lay_wdata = layer_up;
               q_we      = 1'b1;
               q_wdata   = w_ff;
               q_tail_in = q_tail_ff + 1'b1;
            end
            state_in = S_BFS_SCAN;
         end
         S_LAY_CHK: begin
            if (lay_nil_ff == LAYER_INF) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = cnt_ff;
               state_in     = S_IDLE;
            end else begin
               outer_u_in = (VERT_W + 1)'(1);
               state_in   = S_AUG_NEXT;
            end
         end
         // try one augmenting path from each free left vertex
         S_AUG_NEXT: begin
            if (outer_u_ff > (VERT_W + 1)'(nu_ff)) begin
               init_in   = (VERT_W + 1)'(1);
               q_head_in = '0;
               q_tail_in = '0;
               state_in  = S_BFS_INIT;
            end else begin
               outer_u_in = outer_u_ff + 1'b1;
               if (!lmatch_ff[outer_idx]) begin
                  cur_vert_in = VERT_W'(outer_u_ff);
                  cur_next_in = '0;
                  depth_in    = DEPTH_W'(1);
                  adj_raddr   = outer_idx;
                  lay_raddr   = outer_idx;
                  state_in    = S_DFS_LD;
               end
            end
         end
         S_DFS_LD: begin
            cur_layer_in = lay_rdata;
            row_in       = adj_rdata & nv_mask & ~low_mask(cur_next_ff);
            state_in     = S_DFS_SCAN;
         end
         S_DFS_SCAN: begin
            if (first.hit) begin
               cand_col_in       = first.idx;
               row_in[first.idx] = 1'b0;
               cur_next_in       = NEXT_W'(first.idx) + 1'b1;
               state_in          = S_DFS_RP;
            end else begin
               // dead end: drop this vertex from the layering and pop
               lay_we   = 1'b1;
               depth_in = depth_ff - 1'b1;
               state_in = (depth_ff == DEPTH_W'(1)) ? S_AUG_NEXT : S_DFS_POP;
            end
         end
         S_DFS_RP: begin
            if (w_now == '0) begin
               state_in = (lay_nil_ff == layer_up) ? S_AUG_WR : S_DFS_SCAN;
            end else begin
               w_in      = w_now;
               lay_raddr = w_idx;
               state_in  = S_DFS_LW;
            end
         end
         S_DFS_LW: begin
            if (lay_rdata == layer_up && depth_ff < DEPTH_TOP) begin
               st_we       = 1'b1;
               depth_in    = depth_ff + 1'b1;
               cur_vert_in = w_ff;
               cur_next_in = '0;
               adj_raddr   = RIDX_W'(w_ff - 1'b1);
               lay_raddr   = RIDX_W'(w_ff - 1'b1);
               state_in    = S_DFS_LD;
            end else begin
               state_in = S_DFS_SCAN;
            end
         end
         S_DFS_POP: begin
            cur_vert_in = VERT_W'(st_vert_idx) + 1'b1;
            cur_next_in = st_rdata.next;
            adj_raddr   = st_vert_idx;
            lay_raddr   = st_vert_idx;
            state_in    = S_DFS_LD;
         end
         // flip the path, walking the stack from top to bottom
         S_AUG_WR: begin
            rp_we    = 1'b1;
            rp_waddr = COL_W'(cur_next_ff - 1'b1);
            rp_valid_in[COL_W'(cur_next_ff - 1'b1)] = 1'b1;
            lmatch_in[cur_idx] = 1'b1;
            depth_in = depth_ff - 1'b1;
            if (depth_ff == DEPTH_W'(1)) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_AUG_NEXT;
            end else begin
               state_in = S_AUG_RD;
            end
         end
         S_AUG_RD: begin
            cur_vert_in = VERT_W'(st_vert_idx) + 1'b1;
            cur_next_in = st_rdata.next;
            state_in    = S_AUG_WR;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         u_count_ff   <= CNT_MAX_U;
         v_count_ff   <= CNT_MAX_V;
         rsp_valid_ff <= 1'b0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         depth_ff     <= '0;
         cnt_ff       <= '0;
         rp_valid_ff  <= '0;
         lmatch_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         u_count_ff   <= u_count_in;
         v_count_ff   <= v_count_in;
         rsp_valid_ff <= rsp_valid_in;
         q_head_ff    <= q_head_in;
         q_tail_ff    <= q_tail_in;
         depth_ff     <= depth_in;
         cnt_ff       <= cnt_in;
         rp_valid_ff  <= rp_valid_in;
         lmatch_ff    <= lmatch_in;
      end
      nu_ff        <= nu_in;
      nv_ff        <= nv_in;
      lay_nil_ff   <= lay_nil_in;
      cur_layer_ff <= cur_layer_in;
      outer_u_ff   <= outer_u_in;
      init_ff      <= init_in;
      cur_vert_ff  <= cur_vert_in;
      cur_next_ff  <= cur_next_in;
      w_ff         <= w_in;
      row_ff       <= row_in;
      cand_col_ff  <= cand_col_in;
      rsp_size_ff  <= rsp_size_in;
   end

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_TOP) else $error("search stack overflow");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      q_head_ff <= q_tail_ff) else $error("queue head passed tail");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == S_LAY_CHK) else $error("stray result");
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_row) |=> busy) else $error("last row not started");

endmodule
